### rtl/irts_pkg.sv
// Shared types and constants of the impulse response timing search.
// No dependencies; the integrator, width search and top level refer to this package by scoped names.
package irts_pkg;

    localparam int DEF_MAX_FFT    = 1024;
    localparam int DEF_DECIMATION = 4;

    localparam int SAMPLE_W     = 16;
    localparam int STORE_W      = 12;
    localparam int SAMPLE_SHIFT = 4;
    localparam int CURVE_W      = 16;
    localparam int ACC_W        = 32;
    localparam int FFT_W        = 11;
    localparam int GUARD_W      = 10;
    localparam int STEP_W       = 4;
    localparam int OFFSET_W     = 23;
    localparam int INDEX_W      = 13;
    localparam int THR_SHIFT    = 8;
    localparam int OFFSET_SHIFT = 9;

    localparam int GUARD_MAX = (1 << GUARD_W) - 1;
    localparam int STEP_MAX  = (1 << STEP_W) - 1;
    localparam int F_MAX     = GUARD_MAX * 2 * STEP_MAX;
    localparam int F_W       = $clog2(F_MAX + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_FFT_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_STEP   = 2'd2;

    localparam logic [FFT_W-1:0]   FFT_RESET   = 11'd512;
    localparam logic [GUARD_W-1:0] GUARD_RESET = 10'd64;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 4'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_real;
        logic                       last_sample;
    } in_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] timing_offset;
        logic [INDEX_W-1:0]         width_start;
        logic [INDEX_W-1:0]         width_end;
        logic [INDEX_W-1:0]         width_middle;
    } out_t;

    typedef struct packed {
        logic               valid;
        logic [CURVE_W-1:0] value;
    } curve_emit_t;

endpackage

### rtl/irts_integrator.sv
// Sample store and the three cascaded integrators that build the energy curve.
// Depends on irts_pkg; one shared multiplier serves the up and down ramp updates.
module irts_integrator #(
    parameter int MAX_FFT    = irts_pkg::DEF_MAX_FFT,
    parameter int DECIMATION = irts_pkg::DEF_DECIMATION
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [$clog2(2*MAX_FFT)-1:0]  wr_addr,
    input  logic [irts_pkg::STORE_W-1:0]  wr_data,
    input  logic                          start,
    input  logic [$clog2(MAX_FFT+1)-1:0]  fft_n,
    input  logic [irts_pkg::F_W-1:0]      win_len,
    output irts_pkg::curve_emit_t         emit,
    output logic                          done
);

    localparam int NW    = $clog2(MAX_FFT + 1);
    localparam int SAW   = $clog2(2 * MAX_FFT);
    localparam int PosW  = $clog2(irts_pkg::F_MAX + 4 * MAX_FFT + DECIMATION + 1) + 1;
    localparam int SW    = irts_pkg::STORE_W;
    localparam int AW    = irts_pkg::ACC_W;
    localparam int PRW   = SW + NW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_M1   = 3'd3;
    localparam logic [2:0] ST_M2   = 3'd4;
    localparam logic [2:0] ST_M3   = 3'd5;
    localparam logic [2:0] ST_AC   = 3'd6;
    localparam logic [2:0] ST_EM   = 3'd7;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;
    localparam logic [1:0] PH_D = 2'd3;

    logic [SW-1:0] mem [2*MAX_FFT];
    logic [SW-1:0] rdata_u_reg, rdata_d_reg;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       done_reg, done_next;
    logic signed [PosW-1:0] up_reg, up_next, dn_reg, dn_next;
    logic       oku_reg, oku_next, okd_reg, okd_next;
    logic signed [SW-1:0] ru_reg, ru_next, rd_reg, rd_next;
    logic [AW-1:0] box0_reg, box0_next, box1_reg, box1_next;
    logic [AW-1:0] ramp0_reg, ramp0_next, ramp1_reg, ramp1_next;
    logic [AW-1:0] acc_reg, acc_next, mul_reg, mul_next;

    logic signed [PosW-1:0] n_pos, n3, n4, f_pos, dec_pos, diff_u, diff_d;
    logic [SAW-1:0]         addr_u, addr_d;
    logic signed [SW-1:0]   ru_m, rd_m, mul_a;
    logic signed [PRW-1:0]  prod;
    logic [AW-1:0]          ru32, up_term, dn_term;
    logic                   cond, up_act, dn_act;

    assign n_pos   = $signed({{(PosW-NW){1'b0}}, fft_n});
    assign n4      = n_pos <<< 2;
    assign n3      = n_pos + (n_pos <<< 1);
    assign f_pos   = $signed({{(PosW-irts_pkg::F_W){1'b0}}, win_len});
    assign dec_pos = PosW'(DECIMATION);
    assign diff_u  = up_reg - n_pos;
    assign diff_d  = dn_reg - n_pos;
    assign addr_u  = diff_u[SAW-1:0];
    assign addr_d  = diff_d[SAW-1:0];

    assign ru_m  = oku_reg ? $signed(rdata_u_reg) : '0;
    assign rd_m  = okd_reg ? $signed(rdata_d_reg) : '0;
    assign mul_a = (state_reg == ST_M1) ? ru_m : rd_reg;
    assign prod  = mul_a * $signed({1'b0, fft_n});
    assign ru32  = {{(AW-SW){ru_reg[SW-1]}}, ru_reg};

    assign up_act  = (phase_reg == PH_B) || (phase_reg == PH_C);
    assign dn_act  = (phase_reg == PH_C) || (phase_reg == PH_D);
    assign up_term = up_act ? (ramp0_reg << 1) - box0_reg : '0;
    assign dn_term = dn_act ? AW'(0) - (ramp1_reg << 1) - box1_reg : '0;

    always_comb begin
        case (phase_reg)
            PH_B:    cond = up_reg < f_pos;
            PH_D:    cond = dn_reg < n4;
            default: cond = up_reg < n4;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_u_reg <= mem[addr_u];
        rdata_d_reg <= mem[addr_d];
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        up_next    = up_reg;
        dn_next    = dn_reg;
        oku_next   = oku_reg;
        okd_next   = okd_reg;
        ru_next    = ru_reg;
        rd_next    = rd_reg;
        box0_next  = box0_reg;
        box1_next  = box1_reg;
        ramp0_next = ramp0_reg;
        ramp1_next = ramp1_reg;
        acc_next   = acc_reg;
        mul_next   = mul_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_CHK;
                    phase_next = PH_A;
                    up_next    = '0;
                    dn_next    = '0;
                    box0_next  = '0;
                    box1_next  = '0;
                    ramp0_next = '0;
                    ramp1_next = '0;
                    acc_next   = '0;
                end
            end
            ST_CHK: begin
                if (cond) begin
                    state_next = ST_RD;
                end else begin
                    case (phase_reg)
                        PH_A: begin
                            phase_next = PH_B;
                            up_next    = '0;
                        end
                        PH_B: begin
                            phase_next = PH_C;
                            up_next    = f_pos;
                            dn_next    = '0;
                        end
                        PH_C: begin
                            phase_next = PH_D;
                            dn_next    = n4 - f_pos;
                        end
                        default: begin
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD: begin
                // Window positions outside the loaded span read as zero.
                oku_next   = (up_reg >= n_pos) && (up_reg < n3);
                okd_next   = (dn_reg >= n_pos) && (dn_reg < n3);
                state_next = ST_M1;
            end
            ST_M1: begin
                ru_next  = ru_m;
                rd_next  = rd_m;
                mul_next = AW'(prod);
                if (phase_reg == PH_A) begin
                    box0_next = box0_reg + {{(AW-SW){ru_m[SW-1]}}, ru_m};
                end else if (up_act) begin
                    box0_next = box0_reg - {{(AW-SW){ru_m[SW-1]}}, ru_m};
                end
                if (dn_act) begin
                    box1_next = box1_reg + {{(AW-SW){rd_m[SW-1]}}, rd_m};
                end
                state_next = ST_M2;
            end
            ST_M2: begin
                if (phase_reg == PH_A) begin
                    ramp0_next = ramp0_reg + ru32 + box0_reg;
                end else if (up_act) begin
                    ramp0_next = ramp0_reg - mul_reg + box0_reg;
                end
                mul_next   = AW'(prod);
                state_next = ST_M3;
            end
            ST_M3: begin
                if (dn_act) begin
                    ramp1_next = ramp1_reg + mul_reg - box1_reg;
                end
                state_next = ST_AC;
            end
            ST_AC: begin
                if (phase_reg == PH_A) begin
                    acc_next   = acc_reg + ru32 + (ramp0_reg << 1) - box0_reg;
                    state_next = ST_CHK;
                end else begin
                    acc_next   = acc_reg + up_term + dn_term;
                    state_next = ST_EM;
                end
                up_next = up_reg + dec_pos;
                dn_next = dn_reg + dec_pos;
            end
            default: begin
                state_next = ST_CHK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_A;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        up_reg    <= up_next;
        dn_reg    <= dn_next;
        oku_reg   <= oku_next;
        okd_reg   <= okd_next;
        ru_reg    <= ru_next;
        rd_reg    <= rd_next;
        box0_reg  <= box0_next;
        box1_reg  <= box1_next;
        ramp0_reg <= ramp0_next;
        ramp1_reg <= ramp1_next;
        acc_reg   <= acc_next;
        mul_reg   <= mul_next;
    end

    assign emit.valid = (state_reg == ST_EM);
    assign emit.value = acc_reg[AW-1 -: irts_pkg::CURVE_W];
    assign done       = done_reg;

endmodule

### rtl/irts_divider.sv
// Restoring divider, one quotient bit per cycle, for the timing offset scaling.
// Depends on nothing but its parameters.
module irts_divider #(
    parameter int W  = 25,
    parameter int VW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [W-1:0]  quotient
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next, done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/irts_width_search.sv
// Curve store, peak tracking, left and right width walks and timing offset scaling.
// Depends on irts_pkg and irts_divider.
module irts_width_search #(
    parameter int MAX_FFT    = irts_pkg::DEF_MAX_FFT,
    parameter int DECIMATION = irts_pkg::DEF_DECIMATION
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  irts_pkg::curve_emit_t         emit,
    input  logic                          run,
    input  logic [$clog2(MAX_FFT+1)-1:0]  fft_n,
    input  logic [irts_pkg::F_W-1:0]      win_len,
    input  logic [irts_pkg::STEP_W-1:0]   pilot,
    output logic                          done,
    output irts_pkg::out_t                result
);

    localparam int CurveDepth = (4 * MAX_FFT) / DECIMATION
                              + 2 * ((irts_pkg::F_MAX + DECIMATION - 1) / DECIMATION) + 2;
    localparam int CAW = $clog2(CurveDepth);
    localparam int SCW = $clog2(CurveDepth + 1);
    localparam int EW  = $clog2(CurveDepth * DECIMATION + 1);
    localparam int KW  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int DW  = EW + 1;
    localparam int QW  = EW + irts_pkg::OFFSET_SHIFT;
    localparam int VW  = irts_pkg::STEP_W + 1;
    localparam int CVW = irts_pkg::CURVE_W;
    localparam int IW  = irts_pkg::INDEX_W;

    localparam logic [2:0] SS_IDLE = 3'd0;
    localparam logic [2:0] SS_LRD  = 3'd1;
    localparam logic [2:0] SS_LCMP = 3'd2;
    localparam logic [2:0] SS_RRD  = 3'd3;
    localparam logic [2:0] SS_RCMP = 3'd4;
    localparam logic [2:0] SS_MID  = 3'd5;
    localparam logic [2:0] SS_DIFF = 3'd6;
    localparam logic [2:0] SS_DIV  = 3'd7;

    localparam logic [KW-1:0] K_LAST = KW'(DECIMATION - 1);

    logic [CVW-1:0] mem [CurveDepth];
    logic [CVW-1:0] rdata_reg;

    logic [2:0]     state_reg, state_next;
    logic           done_reg, done_next;
    logic [SCW-1:0] steps_reg, steps_next;
    logic [EW-1:0]  spos_reg, spos_next, ppos_reg, ppos_next;
    logic [CAW-1:0] paddr_reg, paddr_next;
    logic [CVW-1:0] peak_reg, peak_next, thr_reg, thr_next;
    logic [EW-1:0]  sv_reg, sv_next, ev_reg, ev_next, mid_reg, mid_next;
    logic [CAW-1:0] sa_reg, sa_next, ea_reg, ea_next;
    logic [KW-1:0]  sk_reg, sk_next, ek_reg, ek_next;
    logic           neg_reg, neg_next;
    irts_pkg::out_t res_reg, res_next;

    logic [CAW-1:0]       rd_addr, last_addr;
    logic [SCW-1:0]       steps_m1;
    logic [EW:0]          mid_sum;
    logic [EW-1:0]        base;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic [QW-1:0]        dividend, quotient, sres;
    logic                 div_start, div_done, at_last;

    assign rd_addr   = (state_reg == SS_LRD) ? sa_reg : ea_reg;
    assign steps_m1  = steps_reg - 1'b1;
    assign last_addr = steps_m1[CAW-1:0];
    assign at_last   = (ea_reg == last_addr) && (ek_reg == K_LAST);
    assign mid_sum   = {1'b0, sv_reg} + {1'b0, ev_reg};
    assign base      = EW'({fft_n, 1'b0}) + EW'(win_len >> 1);
    assign diff      = $signed({1'b0, mid_reg}) - $signed({1'b0, base});
    assign mag       = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign dividend  = {mag[EW-1:0], {irts_pkg::OFFSET_SHIFT{1'b0}}};
    assign div_start = (state_reg == SS_DIFF);
    assign sres      = neg_reg ? QW'(-quotient) : quotient;

    irts_divider #(
        .W  (QW),
        .VW (VW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  ({pilot, 1'b0}),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            mem[steps_reg[CAW-1:0]] <= emit.value;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        steps_next = steps_reg;
        spos_next  = spos_reg;
        ppos_next  = ppos_reg;
        paddr_next = paddr_reg;
        peak_next  = peak_reg;
        thr_next   = thr_reg;
        sv_next    = sv_reg;
        ev_next    = ev_reg;
        sa_next    = sa_reg;
        ea_next    = ea_reg;
        sk_next    = sk_reg;
        ek_next    = ek_reg;
        mid_next   = mid_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        if (clear) begin
            steps_next = '0;
            spos_next  = '0;
            ppos_next  = '0;
            paddr_next = '0;
            peak_next  = '0;
        end else if (emit.valid) begin
            // Only a strictly larger value moves the peak, so the first maximum wins.
            if (emit.value > peak_reg) begin
                peak_next  = emit.value;
                ppos_next  = spos_reg;
                paddr_next = steps_reg[CAW-1:0];
            end
            steps_next = steps_reg + 1'b1;
            spos_next  = spos_reg + EW'(DECIMATION);
        end
        case (state_reg)
            SS_IDLE: begin
                if (run) begin
                    thr_next   = peak_reg - (peak_reg >> irts_pkg::THR_SHIFT);
                    sv_next    = ppos_reg;
                    ev_next    = ppos_reg;
                    sa_next    = paddr_reg;
                    ea_next    = paddr_reg;
                    sk_next    = '0;
                    ek_next    = '0;
                    state_next = (steps_reg == '0) ? SS_MID : SS_LRD;
                end
            end
            SS_LRD: begin
                state_next = (sv_reg == '0) ? SS_RRD : SS_LCMP;
            end
            SS_LCMP: begin
                if (rdata_reg > thr_reg) begin
                    sv_next = sv_reg - 1'b1;
                    if (sk_reg == '0) begin
                        sk_next = K_LAST;
                        sa_next = sa_reg - 1'b1;
                    end else begin
                        sk_next = sk_reg - 1'b1;
                    end
                    state_next = SS_LRD;
                end else begin
                    state_next = SS_RRD;
                end
            end
            SS_RRD: begin
                state_next = at_last ? SS_MID : SS_RCMP;
            end
            SS_RCMP: begin
                if (rdata_reg > thr_reg) begin
                    ev_next = ev_reg + 1'b1;
                    if (ek_reg == K_LAST) begin
                        ek_next = '0;
                        ea_next = ea_reg + 1'b1;
                    end else begin
                        ek_next = ek_reg + 1'b1;
                    end
                    state_next = SS_RRD;
                end else begin
                    state_next = SS_MID;
                end
            end
            SS_MID: begin
                mid_next   = mid_sum[EW:1];
                state_next = SS_DIFF;
            end
            SS_DIFF: begin
                neg_next   = diff[DW-1];
                state_next = SS_DIV;
            end
            default: begin
                if (div_done) begin
                    res_next.timing_offset = $signed(sres[irts_pkg::OFFSET_W-1:0]);
                    res_next.width_start   = sv_reg[IW-1:0];
                    res_next.width_end     = ev_reg[IW-1:0];
                    res_next.width_middle  = mid_reg[IW-1:0];
                    done_next              = 1'b1;
                    state_next             = SS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SS_IDLE;
            done_reg  <= 1'b0;
            steps_reg <= '0;
            spos_reg  <= '0;
            ppos_reg  <= '0;
            paddr_reg <= '0;
            peak_reg  <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
            spos_reg  <= spos_next;
            ppos_reg  <= ppos_next;
            paddr_reg <= paddr_next;
            peak_reg  <= peak_next;
        end
        thr_reg <= thr_next;
        sv_reg  <= sv_next;
        ev_reg  <= ev_next;
        sa_reg  <= sa_next;
        ea_reg  <= ea_next;
        sk_reg  <= sk_next;
        ek_reg  <= ek_next;
        mid_reg <= mid_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### rtl/impulse_response_timing_search.sv
// Top level of the impulse response timing search: ports, configuration and sequencing.
// Depends on irts_pkg, irts_integrator and irts_width_search.
//
//   channel  direction  ports                                    carries
//   s_       in         s_valid s_ready s_data                   one response sample request
//   m_       out        m_valid m_ready m_data                   timing offset and width result
//   cfg_     in         cfg_valid cfg_ready cfg_index cfg_data   register write request
//
// A sample that is not the last is only stored. The last sample starts the curve pass:
// each curve step runs the check, read, three multiply, accumulate and emit states
// (no emit on the accumulate-only first pass), then each walk step reads and compares
// in the curve store, then the offset divider runs. Reset is synchronous and needs no
// clearing pass. Samples are refused until the finished result is loaded for output.
module impulse_response_timing_search #(
    parameter int MAX_FFT    = irts_pkg::DEF_MAX_FFT,
    parameter int DECIMATION = irts_pkg::DEF_DECIMATION
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  irts_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output irts_pkg::out_t                      m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [irts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [irts_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NW  = $clog2(MAX_FFT + 1);
    localparam int SAW = $clog2(2 * MAX_FFT);
    localparam int CW  = $clog2(2 * MAX_FFT + 1);
    localparam int SW  = irts_pkg::STEP_W;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_SRCH = 2'd2;
    localparam logic [1:0] T_WAIT = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          mv_reg, mv_next;
    irts_pkg::out_t                md_reg, md_next;
    logic [irts_pkg::FFT_W-1:0]    fft_reg;
    logic [irts_pkg::GUARD_W-1:0]  guard_reg;
    logic [SW-1:0]                 step_reg;

    logic                          accept, wr_en, start, run, integ_done, srch_done, free;
    logic [NW-1:0]                 fft_n;
    logic [SW-1:0]                 step_eff;
    logic [irts_pkg::F_W-1:0]      win_len;
    irts_pkg::curve_emit_t         emit;
    irts_pkg::out_t                srch_res;

    assign accept   = s_valid && s_ready;
    assign wr_en    = accept && (cnt_reg < CW'(2 * MAX_FFT));
    assign start    = accept && s_data.last_sample;
    assign run      = integ_done;
    assign free     = !mv_reg || m_ready;
    assign fft_n    = (int'(fft_reg) > MAX_FFT) ? NW'(MAX_FFT) : NW'(fft_reg);
    assign step_eff = (step_reg == '0) ? SW'(1) : step_reg;
    assign win_len  = irts_pkg::F_W'(guard_reg) * irts_pkg::F_W'({step_eff, 1'b0});

    assign s_ready   = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = mv_reg;
    assign m_data    = md_reg;

    irts_integrator #(
        .MAX_FFT    (MAX_FFT),
        .DECIMATION (DECIMATION)
    ) u_integ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[SAW-1:0]),
        .wr_data (s_data.sample_real[irts_pkg::SAMPLE_W-1:irts_pkg::SAMPLE_SHIFT]),
        .start   (start),
        .fft_n   (fft_n),
        .win_len (win_len),
        .emit    (emit),
        .done    (integ_done)
    );

    irts_width_search #(
        .MAX_FFT    (MAX_FFT),
        .DECIMATION (DECIMATION)
    ) u_srch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (start),
        .emit    (emit),
        .run     (run),
        .fft_n   (fft_n),
        .win_len (win_len),
        .pilot   (step_eff),
        .done    (srch_done),
        .result  (srch_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fft_reg   <= irts_pkg::FFT_RESET;
            guard_reg <= irts_pkg::GUARD_RESET;
            step_reg  <= irts_pkg::STEP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                irts_pkg::CFG_FFT_SIZE:     fft_reg   <= cfg_data;
                irts_pkg::CFG_GUARD_LENGTH: guard_reg <= cfg_data[irts_pkg::GUARD_W-1:0];
                irts_pkg::CFG_PILOT_STEP:   step_reg  <= cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        md_next    = md_reg;
        case (state_reg)
            T_IDLE: begin
                if (start) begin
                    cnt_next   = '0;
                    state_next = T_RUN;
                end else if (wr_en) begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            T_RUN: begin
                if (integ_done) begin
                    state_next = T_SRCH;
                end
            end
            T_SRCH: begin
                if (srch_done) begin
                    state_next = T_WAIT;
                end
            end
            default: begin
                // The search keeps its result registered until the output stage is free.
                if (free) begin
                    mv_next    = 1'b1;
                    md_next    = srch_res;
                    state_next = T_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        md_reg <= md_next;
    end

`ifndef SYNTHESIS
    a_integ_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        integ_done |-> state_reg == T_RUN)
        else $error("curve pass finished outside the run state");

    a_search_done_in_srch: assert property (@(posedge aclk) disable iff (!aresetn)
        srch_done |-> state_reg == T_SRCH)
        else $error("width search finished outside the search state");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(2 * MAX_FFT))
        else $error("sample count ran past the sample store");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_WAIT && free) |=> (m_valid && state_reg == T_IDLE))
        else $error("finished result was not loaded into the output stage");
`endif

endmodule
